// ===== rtl/core/pafg_pkg.sv =====
package pafg_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 6;
    localparam int ADC_W    = 4;
    localparam int GAIN_W   = 24;
    localparam int SLOPE_W  = 32;
    localparam int MEAN_W   = 16;
    localparam int STAT_W   = 2;
    localparam int CFG_W    = 13;
    localparam int CIDX_W   = 2;
    localparam int SUM_W    = 28;
    localparam int POS_W    = 12;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_DIVZ  = 2'd2;

    localparam logic [CIDX_W-1:0] REG_ADC_COUNT   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_PIXELS      = 2'd1;
    localparam logic [CIDX_W-1:0] REG_LEFT_TRIM   = 2'd2;
    localparam logic [CIDX_W-1:0] REG_RIGHT_BOUND = 2'd3;

    // divider request: unsigned numerator over unsigned denominator
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

endpackage

// ===== rtl/core/pafg_div.sv =====
module pafg_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pafg_pkg::t_div_req i_req,
    output pafg_pkg::t_div_rsp o_rsp
);
    import pafg_pkg::*;

    // restoring divider, one quotient bit per cycle
    logic [63:0] r_num;
    logic [63:0] r_den;
    logic [64:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] n_rem;
    logic [64:0] n_diff;

    always_comb begin
        n_rem  = {r_rem[63:0], r_num[63]};
        n_diff = n_rem - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                if (!n_diff[64]) begin
                    r_rem <= n_diff;
                    r_num <= {r_num[62:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_num <= {r_num[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_num;
endmodule

// ===== rtl/core/per_adc_flat_field_gain_core.sv =====
// channel  | direction | signals
// pixel    | in        | i_start/o_busy, i_sample, i_level_index, i_last_pixel
// config   | in        | i_cfg_we, i_cfg_index, i_cfg_data
// result   | out       | o_valid, o_adc_index, o_gain, o_gain_slope, o_level_mean,
//          |           | o_status, o_last_result
// a pixel without last_pixel leaves busy low
// a last pixel holds busy for the level end: first the adc sums are totalled, then
// two divisions for the mean, then per adc up to a gain and a slope division,
// all through one serial divider
// results come out one beat per adc (one range beat for an out of range level), the receiver cannot stall them
// reset is synchronous, active low; gain and mean tables are undefined until written
module per_adc_flat_field_gain_core #(
    parameter int MAX_ADC            = 16,
    parameter int MAX_LEVELS         = 64,
    parameter int MAX_PIXELS_PER_ADC = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic [pafg_pkg::SAMPLE_W-1:0]         i_sample,
    input  logic [pafg_pkg::LEVEL_W-1:0]          i_level_index,
    input  logic                                  i_last_pixel,
    input  logic                                  i_cfg_we,
    input  logic [pafg_pkg::CIDX_W-1:0]           i_cfg_index,
    input  logic [pafg_pkg::CFG_W-1:0]            i_cfg_data,
    output logic                                  o_valid,
    output logic [pafg_pkg::ADC_W-1:0]            o_adc_index,
    output logic [pafg_pkg::GAIN_W-1:0]           o_gain,
    output logic signed [pafg_pkg::SLOPE_W-1:0]   o_gain_slope,
    output logic [pafg_pkg::MEAN_W-1:0]           o_level_mean,
    output logic [pafg_pkg::STAT_W-1:0]           o_status,
    output logic                                  o_last_result
);
    import pafg_pkg::*;

    localparam int LVL_AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int GT_AW  = LVL_AW + ADC_W;
    localparam logic [4:0]  MAX_ADC_C = 5'(MAX_ADC);
    localparam logic [12:0] MAX_PIX_C = 13'(MAX_PIXELS_PER_ADC);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TOT   = 4'd1;
    localparam logic [3:0] S_MINT  = 4'd2;
    localparam logic [3:0] S_MQ8   = 4'd3;
    localparam logic [3:0] S_GSUM  = 4'd4;
    localparam logic [3:0] S_GDIV  = 4'd5;
    localparam logic [3:0] S_GRD   = 4'd6;
    localparam logic [3:0] S_SDIV  = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_WAIT  = 4'd9;

    // configuration
    logic [4:0]  r_adc_count;
    logic [12:0] r_pix;
    logic [12:0] r_ltrim;
    logic [12:0] r_rbound;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_count <= 5'd9;
            r_pix       <= 13'd64;
            r_ltrim     <= 13'd0;
            r_rbound    <= 13'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ADC_COUNT:   r_adc_count <= i_cfg_data[4:0];
                REG_PIXELS:      r_pix       <= i_cfg_data;
                REG_LEFT_TRIM:   r_ltrim     <= i_cfg_data;
                REG_RIGHT_BOUND: r_rbound    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective counts
    logic [4:0]  n_eff;
    logic [12:0] p_eff;
    always_comb begin
        n_eff = r_adc_count;
        if (n_eff < 5'd1) n_eff = 5'd1;
        if (n_eff > MAX_ADC_C) n_eff = MAX_ADC_C;
        if (n_eff > 5'd16) n_eff = 5'd16;
        p_eff = r_pix;
        if (p_eff < 13'd1) p_eff = 13'd1;
        if (p_eff > MAX_PIX_C) p_eff = MAX_PIX_C;
        if (p_eff > 13'd4096) p_eff = 13'd4096;
    end

    // accumulation state
    logic [SUM_W-1:0]    r_sums [16];
    logic [SAMPLE_W-1:0] r_mid  [16];
    logic [POS_W-1:0]    r_pos;
    logic [4:0]          r_chn;
    logic [3:0]          r_state;
    logic [LEVEL_W-1:0]  r_level;

    logic                accept;
    logic [3:0]          cur_ch;
    logic [POS_W-1:0]    cur_pos;
    logic                clr;

    assign accept = i_start && !o_busy;

    always_comb begin
        cur_ch  = r_chn[3:0];
        cur_pos = r_pos;
        if (r_chn >= n_eff) begin
            cur_ch  = '0;
            cur_pos = r_pos + 12'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_chn <= '0;
            for (int k = 0; k < 16; k++) begin
                r_sums[k] <= '0;
                r_mid[k]  <= '0;
            end
        end else if (clr) begin
            r_pos <= '0;
            r_chn <= '0;
            for (int k = 0; k < 16; k++) begin
                r_sums[k] <= '0;
                r_mid[k]  <= '0;
            end
        end else if (accept) begin
            if ({1'b0, cur_pos} < p_eff) begin
                if ({1'b0, cur_pos} == (p_eff >> 1)) r_mid[cur_ch] <= i_sample;
                if (!({1'b0, cur_pos} < r_ltrim || {1'b0, cur_pos} >= r_rbound))
                    r_sums[cur_ch] <= r_sums[cur_ch] + SUM_W'(i_sample);
            end
            if ({1'b0, cur_ch} + 5'd1 >= n_eff) begin
                r_chn <= '0;
                r_pos <= cur_pos + 12'd1;
            end else begin
                r_chn <= {1'b0, cur_ch} + 5'd1;
                r_pos <= cur_pos;
            end
        end
    end

    // level end sequencer
    t_div_req div_req;
    t_div_rsp div_rsp;
    pafg_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    logic [12:0] hi_b;
    logic [12:0] untrim;
    logic [12:0] trim;
    always_comb begin
        hi_b   = (r_rbound < p_eff) ? r_rbound : p_eff;
        untrim = (hi_b > r_ltrim) ? hi_b - r_ltrim : 13'd0;
        trim   = p_eff - untrim;
    end

    logic [3:0]  r_idx;
    logic [35:0] r_total;
    logic [35:0] r_si;
    logic [MEAN_W-1:0] r_mint;
    logic [23:0] r_mq8;
    logic [23:0] r_g;
    logic [1:0]  r_stat;
    logic [23:0] r_gp;
    logic [23:0] r_mp;
    logic        r_neg;
    logic signed [SLOPE_W-1:0] r_slope;
    logic [1:0]  r_wait;
    logic        r_oval;
    logic [17:0] r_pix_n;

    // tables
    logic [GAIN_W-1:0] r_gtab [MAX_LEVELS*16];
    logic [23:0]       r_mtab [MAX_LEVELS];
    logic [LVL_AW-1:0] lvl_a;
    logic [LVL_AW-1:0] lvlp_a;
    assign lvl_a  = r_level[LVL_AW-1:0];
    assign lvlp_a = lvl_a - 1'b1;

    logic [35:0] si_c;
    assign si_c = 36'(r_sums[r_idx]) + 36'(trim) * 36'(r_mid[r_idx]);

    logic signed [25:0] dg;
    logic signed [25:0] dm;
    assign dg = $signed({2'b0, r_gp}) - $signed({2'b0, r_g});
    assign dm = $signed({2'b0, r_mp}) - $signed({2'b0, r_mq8});

    logic [63:0] q_mag;
    assign q_mag = div_rsp.quo;

    always_comb begin
        clr = 1'b0;
        div_req = '0;
        if (r_state == S_EMIT && ({1'b0, r_idx} + 5'd1 >= n_eff)) clr = 1'b1;
        if (r_state == S_WAIT) clr = 1'b1;
        case (r_state)
            S_MINT: if (r_wait == 2'd0) begin
                div_req.start = 1'b1;
                div_req.num   = 64'(r_total);
                div_req.den   = 64'(r_pix_n);
            end
            S_MQ8: if (r_wait == 2'd0) begin
                div_req.start = 1'b1;
                div_req.num   = 64'(r_total) << 8;
                div_req.den   = 64'(r_pix_n);
            end
            S_GDIV: if (r_wait == 2'd0) begin
                div_req.start = 1'b1;
                div_req.num   = 64'(r_total) << 16;
                div_req.den   = 64'(r_si) * 64'(n_eff);
            end
            S_SDIV: if (r_wait == 2'd0) begin
                // magnitudes through the divider, sign applied afterwards
                div_req.start = 1'b1;
                div_req.num   = 64'(dg[25] ? -dg : dg) << 16;
                div_req.den   = 64'(dm[25] ? -dm : dm);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
            r_wait  <= '0;
            r_idx   <= '0;
        end else begin
            r_oval <= 1'b0;
            case (r_state)
                S_IDLE: if (accept && i_last_pixel) begin
                    r_level <= i_level_index;
                    r_idx   <= '0;
                    r_total <= '0;
                    r_pix_n <= 18'(n_eff) * 18'(p_eff);
                    if (32'(i_level_index) >= MAX_LEVELS) begin
                        o_adc_index   <= '0;
                        o_gain        <= '0;
                        o_gain_slope  <= '0;
                        o_level_mean  <= '0;
                        o_status      <= ST_RANGE;
                        o_last_result <= 1'b1;
                        r_oval        <= 1'b1;
                        r_state       <= S_WAIT;
                    end else begin
                        r_state <= S_TOT;
                    end
                end
                S_TOT: begin
                    // one adc sum per cycle through the shared multiply-add
                    r_total <= r_total + si_c;
                    if ({1'b0, r_idx} + 5'd1 >= n_eff) begin
                        r_idx   <= '0;
                        r_state <= S_MINT;
                        r_wait  <= '0;
                    end else begin
                        r_idx <= r_idx + 4'd1;
                    end
                end
                S_MINT: begin
                    r_wait <= 2'd1;
                    if (div_rsp.done) begin
                        r_mint  <= q_mag[MEAN_W-1:0];
                        r_wait  <= '0;
                        r_state <= S_MQ8;
                    end
                end
                S_MQ8: begin
                    r_wait <= 2'd1;
                    if (div_rsp.done) begin
                        r_mq8   <= q_mag[23:0];
                        r_wait  <= '0;
                        r_state <= S_GSUM;
                    end
                end
                S_GSUM: begin
                    r_si   <= si_c;
                    r_gp   <= r_gtab[{lvlp_a, r_idx}];
                    r_mp   <= r_mtab[lvlp_a];
                    r_wait <= '0;
                    if (si_c == '0) begin
                        r_g     <= 24'hFFFFFF;
                        r_stat  <= ST_DIVZ;
                        r_state <= S_GRD;
                    end else begin
                        r_stat  <= ST_OK;
                        r_state <= S_GDIV;
                    end
                end
                S_GDIV: begin
                    r_wait <= 2'd1;
                    if (div_rsp.done) begin
                        r_g     <= (q_mag > 64'hFFFFFF) ? 24'hFFFFFF : q_mag[23:0];
                        r_wait  <= '0;
                        r_state <= S_GRD;
                    end
                end
                S_GRD: begin
                    r_gtab[{lvl_a, r_idx}] <= r_g;
                    r_wait    <= '0;
                    if (r_level == '0) begin
                        r_slope <= '0;
                        r_state <= S_EMIT;
                    end else if (dm == '0) begin
                        r_stat  <= ST_DIVZ;
                        r_slope <= dg[25] ? 32'sh8000_0000 :
                                   (dg == '0 ? 32'sd0 : 32'sh7FFF_FFFF);
                        r_state <= S_EMIT;
                    end else begin
                        r_neg   <= dg[25] ^ dm[25];
                        r_state <= S_SDIV;
                    end
                end
                S_SDIV: begin
                    r_wait <= 2'd1;
                    if (div_rsp.done) begin
                        if (r_neg)
                            r_slope <= (q_mag > 64'h8000_0000) ? 32'sh8000_0000
                                     : -$signed(q_mag[31:0]);
                        else
                            r_slope <= (q_mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                     : $signed(q_mag[31:0]);
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    o_adc_index   <= r_idx;
                    o_gain        <= r_g;
                    o_gain_slope  <= r_slope;
                    o_level_mean  <= r_mint;
                    o_status      <= r_stat;
                    o_last_result <= ({1'b0, r_idx} + 5'd1 >= n_eff);
                    r_oval        <= 1'b1;
                    if ({1'b0, r_idx} + 5'd1 >= n_eff) begin
                        r_mtab[lvl_a] <= r_mq8;
                        r_state       <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + 4'd1;
                        r_state <= S_GSUM;
                    end
                end
                S_WAIT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_oval;
endmodule

// ===== rtl/core/pafg_checker.sv =====
module pafg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        i_last_pixel,
    input logic        o_valid,
    input logic [1:0]  o_status,
    input logic        o_last_result,
    input logic [23:0] o_gain
);
    import pafg_pkg::*;

    a_no_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy)) else $error("result while idle");

    a_plain_pixel_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !i_last_pixel) |=> !o_busy) else $error("busy after pixel");

    a_last_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_last_pixel) |=> o_busy) else $error("no level end");

    a_range_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_RANGE) |-> (o_last_result && o_gain == '0))
        else $error("bad range result");
endmodule

bind per_adc_flat_field_gain_core pafg_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .i_last_pixel(i_last_pixel), .o_valid(o_valid), .o_status(o_status),
    .o_last_result(o_last_result), .o_gain(o_gain)
);

// ===== verif/per_adc_flat_field_gain_core_tb.sv =====
module per_adc_flat_field_gain_core_tb;
    import pafg_pkg::*;

    // one per-adc result of a level, as the block should report it
    typedef struct {
        logic [ADC_W-1:0]          adc;
        logic [GAIN_W-1:0]         gain;
        logic signed [SLOPE_W-1:0] slope;
        logic [MEAN_W-1:0]         mean;
        logic [STAT_W-1:0]         status;
        logic                      last;
    } t_gain_result;

    // predicts the per-adc gains of each level and holds them until they come out
    class gain_scoreboard;
        logic [4:0]       adc_count;
        logic [CFG_W-1:0] pix_per_adc;
        logic [CFG_W-1:0] trim_lo;
        logic [CFG_W-1:0] trim_hi;
        logic [SUM_W-1:0]    sums[16];
        logic [SAMPLE_W-1:0] mids[16];
        logic [POS_W-1:0]    pos;
        logic [ADC_W-1:0]    chan;
        logic [GAIN_W-1:0]   gain_tab[64][16];
        logic [23:0]         mean_tab[64];
        bit                  filled[64][16];
        t_gain_result        pending[$];

        function new();
            adc_count   = 5'd9;
            pix_per_adc = 13'd64;
            trim_lo     = 13'd0;
            trim_hi     = 13'd64;
            clear_level();
            foreach (filled[l, a]) filled[l][a] = 1'b0;
        endfunction

        function void clear_level();
            foreach (sums[a]) begin
                sums[a] = '0;
                mids[a] = '0;
            end
            pos  = '0;
            chan = '0;
        endfunction

        function int eff_n();
            if (adc_count < 1) return 1;
            if (adc_count > 16) return 16;
            return int'(adc_count);
        endfunction

        function int eff_p();
            if (pix_per_adc < 1) return 1;
            if (pix_per_adc > 4096) return 4096;
            return int'(pix_per_adc);
        endfunction

        function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] d);
            case (idx)
                REG_ADC_COUNT:   adc_count   = d[4:0];
                REG_PIXELS:      pix_per_adc = d;
                REG_LEFT_TRIM:   trim_lo     = d;
                REG_RIGHT_BOUND: trim_hi     = d;
                default: ;
            endcase
        endfunction

        // accepted pixel beat; on the last pixel the level results are worked out
        function void note_pixel(logic [SAMPLE_W-1:0] s, logic [LEVEL_W-1:0] lvl,
                                 logic last);
            int n, p, c, ps, hi, untrimmed, trim;
            longint unsigned tot, sum_i[16], g, mean_q8, mean_int;
            longint gp, dg, dm, slope;
            t_gain_result r;
            n = eff_n();
            p = eff_p();
            c = int'(chan);
            ps = int'(pos);
            if (c >= n) begin
                c = 0;
                ps = (ps + 1) & 12'hfff;
            end
            if (ps < p) begin
                if (ps == p / 2) mids[c] = s;
                if (!(ps < trim_lo || ps >= trim_hi)) sums[c] = sums[c] + s;
            end
            if (c + 1 >= n) begin
                chan = '0;
                pos = POS_W'(ps + 1);
            end else begin
                chan = ADC_W'(c + 1);
                pos = POS_W'(ps);
            end
            if (!last) return;
            hi = (trim_hi < p) ? int'(trim_hi) : p;
            untrimmed = (hi > trim_lo) ? hi - int'(trim_lo) : 0;
            trim = p - untrimmed;
            tot = 0;
            for (int i = 0; i < n; i++) begin
                sum_i[i] = longint'(sums[i]) + longint'(trim) * longint'(mids[i]);
                tot += sum_i[i];
            end
            mean_int = tot / (n * p);
            mean_q8 = ((tot * 256) / (n * p)) & 24'hffffff;
            for (int i = 0; i < n; i++) begin
                r.status = ST_OK;
                slope = 0;
                if (sum_i[i] == 0) begin
                    g = 24'hffffff;
                    r.status = ST_DIVZ;
                end else begin
                    g = (tot * 65536) / (n * sum_i[i]);
                    if (g > 24'hffffff) g = 24'hffffff;
                end
                if (lvl > 0) begin
                    gp = longint'(gain_tab[lvl-1][i]);
                    dg = gp - longint'(g);
                    dm = longint'(mean_tab[lvl-1]) - longint'(mean_q8);
                    if (dm == 0) begin
                        r.status = ST_DIVZ;
                        slope = (dg > 0) ? 64'sd2147483647 :
                                (dg < 0) ? -64'sd2147483648 : 0;
                    end else begin
                        slope = (dg * 65536) / dm;
                        if (slope > 64'sd2147483647) slope = 64'sd2147483647;
                        if (slope < -64'sd2147483648) slope = -64'sd2147483648;
                    end
                end
                gain_tab[lvl][i] = GAIN_W'(g);
                filled[lvl][i] = 1'b1;
                r.adc   = ADC_W'(i);
                r.gain  = GAIN_W'(g);
                r.slope = SLOPE_W'(slope);
                r.mean  = MEAN_W'(mean_int);
                r.last  = (i + 1 == n);
                pending.push_back(r);
            end
            mean_tab[lvl] = mean_q8[23:0];
            clear_level();
        endfunction

        // returns an empty string when the beat matches the oldest expectation
        function string check_result(t_gain_result got);
            t_gain_result w;
            if (pending.size() == 0)
                return $sformatf("adc %0d result with nothing expected", got.adc);
            w = pending.pop_front();
            if (got.adc !== w.adc || got.gain !== w.gain || got.slope !== w.slope ||
                got.mean !== w.mean || got.status !== w.status || got.last !== w.last)
                return $sformatf("adc %0d/%0d gain %h/%h slope %h/%h mean %h/%h st %0d/%0d last %b/%b",
                    got.adc, w.adc, got.gain, w.gain, got.slope, w.slope, got.mean, w.mean,
                    got.status, w.status, got.last, w.last);
            return "";
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_start;
    logic                      o_busy;
    logic [SAMPLE_W-1:0]       i_sample;
    logic [LEVEL_W-1:0]        i_level_index;
    logic                      i_last_pixel;
    logic                      i_cfg_we;
    logic [CIDX_W-1:0]         i_cfg_index;
    logic [CFG_W-1:0]          i_cfg_data;
    logic                      o_valid;
    logic [ADC_W-1:0]          o_adc_index;
    logic [GAIN_W-1:0]         o_gain;
    logic signed [SLOPE_W-1:0] o_gain_slope;
    logic [MEAN_W-1:0]         o_level_mean;
    logic [STAT_W-1:0]         o_status;
    logic                      o_last_result;

    per_adc_flat_field_gain_core u_dut (.*);

    localparam int STALL_LIMIT = 20000;

    gain_scoreboard sb = new();
    int  errors;
    int  pixels_sent;
    int  results_seen;
    int  levels_sent;
    int  stall_cycles;
    bit  quiet;        // no sender gaps while set
    int  prev_level;

    always #6 i_clk = ~i_clk;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // result beats cannot be held off, so every strobe is checked at its edge
    always @(posedge i_clk) begin
        t_gain_result got;
        string msg;
        if (i_rst_n && o_valid) begin
            got.adc    = o_adc_index;
            got.gain   = o_gain;
            got.slope  = o_gain_slope;
            got.mean   = o_level_mean;
            got.status = o_status;
            got.last   = o_last_result;
            msg = sb.check_result(got);
            results_seen++;
            if (msg != "") report(msg);
        end
    end

    // watchdog: cycles with neither a pixel beat nor a result beat
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (i_start && !o_busy)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // one pixel beat; start is left high so back-to-back beats need no re-raise
    task automatic send_pixel(input logic [SAMPLE_W-1:0] s, input logic [LEVEL_W-1:0] lvl,
                              input logic last);
        if (!quiet && $urandom_range(0, 99) < 24) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_sample      <= s;
        i_level_index <= lvl;
        i_last_pixel  <= last;
        do @(posedge i_clk); while (o_busy);
        sb.note_pixel(s, lvl, last);
        pixels_sent++;
    endtask

    // wait until the block has no level end in flight
    task automatic settle();
        i_start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_cfg(input int n, input int p, input int lo, input int hi);
        logic [CFG_W-1:0]  vals[4];
        logic [CIDX_W-1:0] idx[4];
        settle();
        vals = '{CFG_W'(n), CFG_W'(p), CFG_W'(lo), CFG_W'(hi)};
        idx  = '{REG_ADC_COUNT, REG_PIXELS, REG_LEFT_TRIM, REG_RIGHT_BOUND};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            sb.write_reg(idx[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // a level may chain a slope only off a previous level that holds every channel
    function automatic bit level_ok(input int l);
        if (l == 0) return 1'b1;
        if (l > 63) return 1'b0;
        for (int i = 0; i < sb.eff_n(); i++)
            if (!sb.filled[l-1][i]) return 1'b0;
        return 1'b1;
    endfunction

    // kind: 0 random, 1 all full scale, 2 all zero, 3 mixed extremes
    task automatic send_level(input int lvl, input int count, input int kind);
        logic [SAMPLE_W-1:0] s;
        for (int k = 0; k < count; k++) begin
            case (kind)
                1: s = 16'hffff;
                2: s = 16'h0000;
                3: s = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
                default: s = $urandom_range(0, 65535);
            endcase
            if (k == count - 1) send_pixel(s, LEVEL_W'(lvl), 1'b1);
            else send_pixel(s, LEVEL_W'($urandom_range(0, 63)), 1'b0);
        end
        levels_sent++;
        prev_level = lvl;
    endtask

    initial begin
        int lvl, cnt, extra;
        i_clk = 0;
        i_rst_n = 0;
        i_start = 0;
        i_sample = '0;
        i_level_index = '0;
        i_last_pixel = 0;
        i_cfg_we = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        quiet = 1'b0;
        prev_level = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: four channels, chained levels incl. zero sums and equal means
        set_cfg(4, 4, 0, 4);
        send_level(0, 16, 0);
        send_level(1, 16, 1);
        send_level(2, 16, 2);
        send_level(3, 16, 2);
        send_level(4, 16, 3);
        // every position trimmed, pixels past the end of the level
        set_cfg(16, 2, 1, 1);
        send_level(0, 40, 0);
        // smallest sizes through the zero register values
        set_cfg(0, 0, 0, 0);
        send_level(0, 1, 1);
        send_level(1, 1, 0);
        // channel count lowered in the middle of a level, below the current channel
        set_cfg(4, 3, 0, 3);
        for (int k = 0; k < 7; k++) send_pixel($urandom_range(0, 65535), 6'd0, 1'b0);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_ADC_COUNT;
        i_cfg_data  <= 13'd2;
        @(posedge i_clk);
        sb.write_reg(REG_ADC_COUNT, 13'd2);
        i_cfg_we <= 1'b0;
        send_level(0, 4, 0);
        // register values above the limits, trim window at the top of the register range
        set_cfg(31, 8191, 100, 8191);
        quiet = 1'b1;
        send_level(0, 64, 0);
        quiet = 1'b0;

        // random: short chained levels, now and then broken in length
        while (pixels_sent < 370) begin
            if ($urandom_range(0, 3) == 0)
                set_cfg($urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 4),
                        $urandom_range(0, 9) == 0 ? $urandom_range(0, 8191) % 7 :
                                                    $urandom_range(0, 5),
                        $urandom_range(0, 4) == 0 ? $urandom_range(0, 8191) : $urandom_range(0, 3),
                        $urandom_range(0, 4) == 0 ? $urandom_range(0, 8191) : $urandom_range(1, 6));
            quiet = (pixels_sent > 260 && pixels_sent < 330);
            lvl = ($urandom_range(0, 5) == 0) ? 0 : prev_level + 1;
            if (!level_ok(lvl)) lvl = 0;
            cnt = sb.eff_n() * sb.eff_p();
            extra = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) - 2 : 0;
            if (cnt + extra < 1) extra = 0;
            send_level(lvl, cnt + extra, $urandom_range(0, 9) == 0 ? 3 : 0);
        end

        settle();
        repeat (200) @(posedge i_clk);
        $display("covered %0d pixel beats in %0d levels, %0d result beats checked",
                 pixels_sent, levels_sent, results_seen);
        if (errors == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results never seen", errors, sb.pending.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
